// ===== rtl/core/paged_binary_min_heap_macros.svh =====
// Assertion macros shared by the paged binary min-heap RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef PAGED_BINARY_MIN_HEAP_MACROS_SVH
`define PAGED_BINARY_MIN_HEAP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PBH_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PBH_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/pbheap_pkg.sv =====
// Package for the paged binary min-heap: operation and status codes, page formulas.
// Depends on nothing.
package pbheap_pkg;
  localparam int CAPACITY_DEF = 1023;
  localparam int PAGE_ENTRIES_DEF = 16;
  localparam int HANDLES_DEF = 1024;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_PEEK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef logic [16:0] slot_t;

  // Parent slot in the paged layout.
  function automatic slot_t parent_of(input slot_t key, input int page, input int pshift);
    slot_t pmask;
    slot_t low;
    slot_t p;
    begin
      pmask = slot_t'(page - 1);
      low = key & pmask;
      if (key < slot_t'(page) || low > slot_t'(3)) begin
        p = (key & ~pmask) | (low >> 1);
      end else if (low < slot_t'(2)) begin
        p = (key - slot_t'(page)) >> pshift;
        p = p + (p & ~(pmask >> 1));
        p = p | slot_t'(page / 2);
      end else begin
        p = key - slot_t'(2);
      end
      return p;
    end
  endfunction

  // First child; the second is first + 1 unless single.
  function automatic slot_t child_of(input slot_t key, input int page, input int pshift,
                                     output logic single);
    slot_t pmask;
    slot_t t;
    slot_t a;
    begin
      pmask = slot_t'(page - 1);
      single = 1'b0;
      if (key > pmask && (key & (pmask - slot_t'(1))) == '0) begin
        a = key + slot_t'(2);
        single = 1'b1;
      end else if ((key & slot_t'(page / 2)) != '0) begin
        t = (((key & ~pmask) >> 1) | (key & (pmask >> 1))) + slot_t'(1);
        a = t << pshift;
      end else begin
        a = key + (key & pmask);
      end
      return a;
    end
  endfunction
endpackage

// ===== rtl/core/pbheap_store.sv =====
// Slot memory of the heap: handle and priority per slot, one port each cycle.
// Depends on pbheap_pkg.
module pbheap_store
  import pbheap_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int SW = $clog2(CAPACITY + 1),
  parameter int HW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] addr,
  input  logic [HW-1:0] wr_handle,
  input  logic [63:0]   wr_prio,
  output logic [HW-1:0] rd_handle,
  output logic [63:0]   rd_prio
);
  logic [HW-1:0] mem_h [CAPACITY+1];
  logic [63:0] mem_p [CAPACITY+1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_h[addr] <= wr_handle;
      mem_p[addr] <= wr_prio;
    end
    rd_handle <= mem_h[addr];
    rd_prio <= mem_p[addr];
  end
endmodule

// ===== rtl/core/paged_binary_min_heap.sv =====
// Paged binary min-heap: handle-tracked min-priority queue with a page-friendly layout.
// A transaction looks up the handle table, sifts the entry up (and down for remove or update)
// through the single slot memory port, then reads the top; one transaction at a time.
// Reset: synchronous; afterwards a clearing pass over all HANDLES entries empties the
// handle table while s_axis_tready stays low.
// Depends on pbheap_pkg, pbheap_store and paged_binary_min_heap_macros.svh.
`include "paged_binary_min_heap_macros.svh"
module paged_binary_min_heap
  import pbheap_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF,
  parameter int HANDLES = HANDLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // func[1:0], handle[11:2], prio[75:12], zero fill
  input  logic         m_axis_tready,
  output logic         m_axis_tvalid,
  output logic [103:0] m_axis_tdata   // status, count, top_valid, top_handle, top_prio,
                                      // final_position, zero fill
);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int HAW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int PSH = $clog2(PAGE_ENTRIES);
  localparam int HW = 10;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RDPOS, S_WRNEW, S_RMLAST, S_RMLAST2, S_RMWR,
    S_UPWR, S_UPRD_K, S_UPRD_P, S_UPCMP, S_UPSW2, S_DNRD_K, S_DNRD_A, S_DNRD_B,
    S_DNCMP, S_DNSW2, S_TOPRD, S_TOPWAIT, S_RESP
  } state_t;

  state_t state;
  logic [HAW-1:0] hpos_addr;
  logic [SW-1:0] hpos [HANDLES];
  logic [SW-1:0] hpos_rd;
  logic hpos_we;
  logic [SW-1:0] hpos_wd;
  logic [HAW-1:0] hpos_wa;

  logic [1:0] func;
  logic [HW-1:0] handle;
  logic [63:0] prio;
  logic in_table;
  logic [SW:0] nfree;
  logic [SW-1:0] pos;
  logic [SW-1:0] key;
  logic [SW-1:0] other;
  logic [HW-1:0] k_h;
  logic [63:0] k_p;
  logic dn_pick_b;
  logic sw_go;
  logic [HW-1:0] sw_h;
  logic [63:0] sw_p;
  logic [HW-1:0] a_h;
  logic [63:0] a_p;
  logic [SW-1:0] a_slot;
  logic b_ok;
  logic [1:0] status;
  logic [HW-1:0] top_h;
  logic [63:0] top_p;
  logic [103:0] out_data;
  logic [HAW-1:0] clr;

  logic mem_we;
  logic [SW-1:0] mem_addr;
  logic [HW-1:0] mem_wh;
  logic [63:0] mem_wp;
  logic [HW-1:0] mem_rh;
  logic [63:0] mem_rp;

  pbheap_store #(.CAPACITY(CAPACITY), .SW(SW), .HW(HW)) u_store (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wr_handle(mem_wh), .wr_prio(mem_wp),
    .rd_handle(mem_rh), .rd_prio(mem_rp)
  );

  always_ff @(posedge clk) begin
    if (hpos_we) begin
      hpos[hpos_wa] <= hpos_wd;
    end
    hpos_rd <= hpos[hpos_addr];
  end

  function automatic logic prio_less(input logic [63:0] x, input logic [63:0] y);
    return $signed(x) < $signed(y);
  endfunction

  slot_t par;
  slot_t ch;
  logic ch_single;
  logic [SW:0] cnt;
  logic present;
  always_comb begin
    par = parent_of(slot_t'(key), PAGE_ENTRIES, PSH);
    ch = child_of(slot_t'(key), PAGE_ENTRIES, PSH, ch_single);
    cnt = nfree - (SW+1)'(1);
    present = in_table && hpos_rd != '0 && {1'b0, hpos_rd} < nfree;
    dn_pick_b = b_ok && prio_less(mem_rp, a_p);
    if (state == S_UPCMP) begin
      sw_h = mem_rh;
      sw_p = mem_rp;
      sw_go = prio_less(k_p, mem_rp);
    end else begin
      sw_h = dn_pick_b ? mem_rh : a_h;
      sw_p = dn_pick_b ? mem_rp : a_p;
      sw_go = !prio_less(k_p, sw_p);
    end
  end

  // Memory and table port control; one access per cycle.
  always_comb begin
    mem_we = 1'b0;
    mem_addr = key;
    mem_wh = k_h;
    mem_wp = k_p;
    hpos_we = 1'b0;
    hpos_wa = k_h[HAW-1:0];
    hpos_wd = key;
    hpos_addr = handle[HAW-1:0];
    unique case (state)
      S_CLEAR: begin
        hpos_we = 1'b1;
        hpos_wa = clr;
        hpos_wd = '0;
      end
      S_WRNEW: begin
        mem_we = 1'b1;
        mem_addr = nfree[SW-1:0];
        mem_wh = handle;
        mem_wp = prio;
        hpos_we = 1'b1;
        hpos_wa = handle[HAW-1:0];
        hpos_wd = nfree[SW-1:0];
      end
      S_RMLAST: begin
        mem_addr = cnt[SW-1:0];
        hpos_we = 1'b1;
        hpos_wa = handle[HAW-1:0];
        hpos_wd = '0;
      end
      S_RMWR: begin
        mem_we = 1'b1;
        mem_addr = pos;
        mem_wh = k_h;
        mem_wp = k_p;
        hpos_we = 1'b1;
        hpos_wa = k_h[HAW-1:0];
        hpos_wd = pos;
      end
      S_UPWR: begin
        mem_we = 1'b1;
        mem_addr = pos;
        mem_wh = k_h;
        mem_wp = prio;
      end
      S_UPRD_K, S_DNRD_K: mem_addr = key;
      S_UPRD_P: mem_addr = par[SW-1:0];
      S_DNRD_A: mem_addr = ch[SW-1:0];
      S_DNRD_B: mem_addr = ch[SW-1:0] + SW'(1);
      S_UPCMP, S_DNCMP: begin
        mem_we = sw_go;
        mem_addr = key;
        mem_wh = sw_h;
        mem_wp = sw_p;
        hpos_we = sw_go;
        hpos_wa = sw_h[HAW-1:0];
        hpos_wd = key;
      end
      S_UPSW2, S_DNSW2: begin
        mem_we = 1'b1;
        mem_addr = other;
        mem_wh = k_h;
        mem_wp = k_p;
        hpos_we = 1'b1;
        hpos_wa = k_h[HAW-1:0];
        hpos_wd = other;
      end
      S_TOPRD, S_TOPWAIT: mem_addr = SW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      nfree <= (SW+1)'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + HAW'(1);
          if (clr == HAW'(HANDLES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func <= s_axis_tdata[1:0];
            handle <= s_axis_tdata[11:2];
            prio <= s_axis_tdata[75:12];
            in_table <= {22'd0, s_axis_tdata[11:2]} < 32'(HANDLES);
            status <= ST_OK;
            state <= S_RDPOS;
          end
        end
        S_RDPOS: state <= S_DISPATCH;
        S_DISPATCH: begin
          pos <= hpos_rd;
          key <= hpos_rd;
          unique case (func_t'(func))
            FUNC_INSERT: begin
              if (!in_table) begin
                status <= ST_ABSENT;
                state <= S_TOPRD;
              end else if (present) begin
                status <= ST_PRESENT;
                state <= S_TOPRD;
              end else if (cnt >= (SW+1)'(CAPACITY)) begin
                status <= ST_FULL;
                state <= S_TOPRD;
              end else begin
                state <= S_WRNEW;
              end
            end
            FUNC_REMOVE: begin
              if (!present) begin
                status <= ST_ABSENT;
                state <= S_TOPRD;
              end else begin
                state <= S_RMLAST;
              end
            end
            FUNC_UPDATE: begin
              if (!present) begin
                status <= ST_ABSENT;
                state <= S_TOPRD;
              end else begin
                k_h <= handle;
                state <= S_UPWR;
              end
            end
            FUNC_PEEK: state <= S_TOPRD;
            default: state <= S_TOPRD;
          endcase
        end
        S_WRNEW: begin
          key <= nfree[SW-1:0];
          nfree <= nfree + (SW+1)'(1);
          state <= S_UPRD_K;
        end
        S_RMLAST: begin
          nfree <= cnt;
          state <= ({1'b0, pos} == cnt) ? S_TOPRD : S_RMLAST2;
        end
        S_RMLAST2: begin
          k_h <= mem_rh;
          k_p <= mem_rp;
          state <= S_RMWR;
        end
        S_RMWR: state <= S_UPRD_K;
        S_UPWR: state <= S_UPRD_K;
        S_UPRD_K: begin
          if (key <= SW'(1) || par == '0 || par >= slot_t'(key)) begin
            state <= (func_t'(func) == FUNC_INSERT) ? S_TOPRD : S_DNRD_K;
          end else begin
            state <= S_UPRD_P;
          end
        end
        S_UPRD_P: begin
          k_h <= mem_rh;
          k_p <= mem_rp;
          other <= par[SW-1:0];
          state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (sw_go) begin
            state <= S_UPSW2;
          end else begin
            state <= (func_t'(func) == FUNC_INSERT) ? S_TOPRD : S_DNRD_K;
          end
        end
        S_UPSW2: begin
          key <= other;
          state <= S_UPRD_K;
        end
        S_DNRD_K: begin
          if (ch >= slot_t'(nfree) || ch <= slot_t'(key)) begin
            state <= S_TOPRD;
          end else begin
            b_ok <= !ch_single && (ch + slot_t'(1)) < slot_t'(nfree);
            a_slot <= ch[SW-1:0];
            state <= S_DNRD_A;
          end
        end
        S_DNRD_A: begin
          k_h <= mem_rh;
          k_p <= mem_rp;
          state <= S_DNRD_B;
        end
        S_DNRD_B: begin
          a_h <= mem_rh;
          a_p <= mem_rp;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          other <= dn_pick_b ? a_slot + SW'(1) : a_slot;
          state <= sw_go ? S_DNSW2 : S_TOPRD;
        end
        S_DNSW2: begin
          key <= other;
          state <= S_DNRD_K;
        end
        S_TOPRD: state <= S_TOPWAIT;
        S_TOPWAIT: begin
          top_h <= mem_rh;
          top_p <= mem_rp;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_data <= {7'd0, in_table ? HW'(hpos_rd) : HW'(0),
                         (cnt != '0) ? top_p : 64'd0,
                         (cnt != '0) ? top_h : HW'(0),
                         cnt != '0, HW'(cnt), status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (m_axis_tvalid && m_axis_tready && !(state == S_RESP)) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // The compare states write the parent or chosen child into the current slot only
  // when the swap proceeds.
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata = out_data;

  `PBH_ASSERT_IMP(a_busy_no_ready, clk, rst, state != S_IDLE, !s_axis_tready, "ready while busy")
  `PBH_ASSERT_IMP(a_count_range, clk, rst, 1'b1, nfree <= (SW+1)'(CAPACITY + 1), "count overflow")
  `PBH_ASSERT_NXT(a_accept_busy, clk, rst, s_axis_tvalid && s_axis_tready, state == S_RDPOS,
                  "accept did not start")
endmodule
